>>> sv/dfg_pkg.sv
// Package for the frequency governor: shared types, register indexes and constants.
// Has no dependencies. All other files of the governor refer to it by scoped names.
`timescale 1ns / 1ps

package dfg_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_HARD_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_EASY_THRESHOLD = 3'd1;
   localparam logic [2:0] REG_EASY_TICKS     = 3'd2;
   localparam logic [2:0] REG_DOWN_TICKS     = 3'd3;
   localparam logic [2:0] REG_FREQ_FLOOR     = 3'd4;
   localparam logic [2:0] REG_FREQ_CEILING   = 3'd5;
   localparam logic [2:0] REG_FREQ_HIGH      = 3'd6;
   localparam logic [2:0] REG_FREQ_LOW       = 3'd7;

   localparam int unsigned LOAD_BITS = 7;
   localparam int unsigned TICK_BITS = 8;
   localparam int unsigned DIR_BITS  = 2;

   // Reset values of the registers.
   localparam logic [LOAD_BITS-1:0] HARD_THRESHOLD_RST = 7'd90;
   localparam logic [LOAD_BITS-1:0] EASY_THRESHOLD_RST = 7'd75;
   localparam logic [TICK_BITS-1:0] EASY_TICKS_RST     = 8'd48;
   localparam logic [TICK_BITS-1:0] DOWN_TICKS_RST     = 8'd24;
   localparam int unsigned FREQ_FLOOR_RST   = 800;
   localparam int unsigned FREQ_CEILING_RST = 1200;
   localparam int unsigned FREQ_HIGH_RST    = 1200;
   localparam int unsigned FREQ_LOW_RST     = 800;

   // The 120/10000 load scaling, reduced by their common factor of 40.
   localparam int unsigned SCALE_NUM = 3;
   localparam int unsigned SCALE_DEN = 250;
   // Bits that SCALE_NUM and SCALE_DEN add to a frequency.
   localparam int unsigned NUM_BITS  = 2;
   localparam int unsigned DEN_BITS  = 8;

   localparam logic [TICK_BITS-1:0] TICK_MAX = 8'hFF;

   typedef enum logic [DIR_BITS-1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   // Threshold and tick settings; the frequency settings scale with the
   // frequency width and travel as ports of their own.
   typedef struct packed {
      logic [LOAD_BITS-1:0] hard_threshold;
      logic [LOAD_BITS-1:0] easy_threshold;
      logic [TICK_BITS-1:0] easy_ticks;
      logic [TICK_BITS-1:0] down_ticks;
   } ctl_cfg_type;

endpackage

>>> sv/dfg_csr.sv
// Configuration register file of the frequency governor, with the derived
// slow-down bounds. Depends on dfg_pkg.
`timescale 1ns / 1ps

module dfg_csr #(
   parameter int unsigned FREQ_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [2:0]                          wr_addr,
   input  logic [FREQ_BITS-1:0]                wr_data,
   output dfg_pkg::ctl_cfg_type                ctl,
   output logic [FREQ_BITS-1:0]                freq_floor,
   output logic [FREQ_BITS-1:0]                freq_ceiling,
   output logic [FREQ_BITS-1:0]                freq_high,
   output logic [FREQ_BITS-1:0]                freq_low,
   output logic [FREQ_BITS+dfg_pkg::NUM_BITS-1:0] high_x3,
   output logic [FREQ_BITS+dfg_pkg::DEN_BITS:0]   low_bound
);

   localparam int unsigned HX_BITS = FREQ_BITS + dfg_pkg::NUM_BITS;
   localparam int unsigned LB_BITS = FREQ_BITS + dfg_pkg::DEN_BITS + 1;

   localparam logic [FREQ_BITS-1:0] FLOOR_RST = FREQ_BITS'(dfg_pkg::FREQ_FLOOR_RST);
   localparam logic [FREQ_BITS-1:0] CEIL_RST  = FREQ_BITS'(dfg_pkg::FREQ_CEILING_RST);
   localparam logic [FREQ_BITS-1:0] HIGH_RST  = FREQ_BITS'(dfg_pkg::FREQ_HIGH_RST);
   localparam logic [FREQ_BITS-1:0] LOW_RST   = FREQ_BITS'(dfg_pkg::FREQ_LOW_RST);

   dfg_pkg::ctl_cfg_type       ctl_ff, ctl_in;
   logic [FREQ_BITS-1:0]       floor_ff, floor_in;
   logic [FREQ_BITS-1:0]       ceil_ff, ceil_in;
   logic [FREQ_BITS-1:0]       high_ff, high_in;
   logic [FREQ_BITS-1:0]       low_ff, low_in;
   logic [HX_BITS-1:0]         high_x3_ff, high_x3_in;
   logic [LB_BITS-1:0]         low_bound_ff, low_bound_in;

   // high * 3 and (low + 1) * 250 are kept alongside the raw settings, so the
   // per-item slow-down test is one narrow multiply and a compare.
   function automatic logic [HX_BITS-1:0] times_num(input logic [FREQ_BITS-1:0] f);
      times_num = HX_BITS'(f) * HX_BITS'(dfg_pkg::SCALE_NUM);
   endfunction

   function automatic logic [LB_BITS-1:0] bound_of(input logic [FREQ_BITS-1:0] f);
      bound_of = (LB_BITS'(f) + LB_BITS'(1)) * LB_BITS'(dfg_pkg::SCALE_DEN);
   endfunction

   always_comb begin
      ctl_in   = ctl_ff;
      floor_in = floor_ff;
      ceil_in  = ceil_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      if (wr_en) begin
         unique case (wr_addr)
            dfg_pkg::REG_HARD_THRESHOLD: ctl_in.hard_threshold = wr_data[dfg_pkg::LOAD_BITS-1:0];
            dfg_pkg::REG_EASY_THRESHOLD: ctl_in.easy_threshold = wr_data[dfg_pkg::LOAD_BITS-1:0];
            dfg_pkg::REG_EASY_TICKS:     ctl_in.easy_ticks     = wr_data[dfg_pkg::TICK_BITS-1:0];
            dfg_pkg::REG_DOWN_TICKS:     ctl_in.down_ticks     = wr_data[dfg_pkg::TICK_BITS-1:0];
            dfg_pkg::REG_FREQ_FLOOR:     floor_in = wr_data;
            dfg_pkg::REG_FREQ_CEILING:   ceil_in  = wr_data;
            dfg_pkg::REG_FREQ_HIGH:      high_in  = wr_data;
            dfg_pkg::REG_FREQ_LOW:       low_in   = wr_data;
            default: ;
         endcase
      end
      high_x3_in   = times_num(high_in);
      low_bound_in = bound_of(low_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.hard_threshold <= dfg_pkg::HARD_THRESHOLD_RST;
         ctl_ff.easy_threshold <= dfg_pkg::EASY_THRESHOLD_RST;
         ctl_ff.easy_ticks     <= dfg_pkg::EASY_TICKS_RST;
         ctl_ff.down_ticks     <= dfg_pkg::DOWN_TICKS_RST;
         floor_ff     <= FLOOR_RST;
         ceil_ff      <= CEIL_RST;
         high_ff      <= HIGH_RST;
         low_ff       <= LOW_RST;
         high_x3_ff   <= times_num(HIGH_RST);
         low_bound_ff <= bound_of(LOW_RST);
      end else begin
         ctl_ff       <= ctl_in;
         floor_ff     <= floor_in;
         ceil_ff      <= ceil_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         high_x3_ff   <= high_x3_in;
         low_bound_ff <= low_bound_in;
      end
   end

   assign ctl          = ctl_ff;
   assign freq_floor   = floor_ff;
   assign freq_ceiling = ceil_ff;
   assign freq_high    = high_ff;
   assign freq_low     = low_ff;
   assign high_x3      = high_x3_ff;
   assign low_bound    = low_bound_ff;

endmodule

>>> sv/dfg_core.sv
// Decision logic and tick-counter state of the frequency governor.
// Depends on dfg_pkg; fed by dfg_csr and the input register of the top level.
`timescale 1ns / 1ps

module dfg_core #(
   parameter int unsigned FREQ_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step,
   input  logic [dfg_pkg::LOAD_BITS-1:0]          peak_load,
   input  logic [FREQ_BITS-1:0]                   present_freq,
   input  dfg_pkg::ctl_cfg_type                   ctl,
   input  logic [FREQ_BITS-1:0]                   freq_floor,
   input  logic [FREQ_BITS-1:0]                   freq_ceiling,
   input  logic [FREQ_BITS-1:0]                   freq_high,
   input  logic [FREQ_BITS-1:0]                   freq_low,
   input  logic [FREQ_BITS+dfg_pkg::NUM_BITS-1:0] high_x3,
   input  logic [FREQ_BITS+dfg_pkg::DEN_BITS:0]   low_bound,
   output logic [FREQ_BITS-1:0]                   wanted_freq,
   output dfg_pkg::dir_type                       direction
);

   localparam int unsigned CMP_BITS = FREQ_BITS + dfg_pkg::DEN_BITS + 1;

   logic                           easy_active_ff, easy_active_in;
   logic [dfg_pkg::TICK_BITS-1:0]  easy_cnt_ff, easy_cnt_in;
   logic [dfg_pkg::TICK_BITS-1:0]  quiet_cnt_ff, quiet_cnt_in;

   logic [dfg_pkg::LOAD_BITS-1:0]  threshold;
   logic [CMP_BITS-1:0]            scaled;
   logic                           request;
   logic [FREQ_BITS-1:0]           target;
   logic [FREQ_BITS-1:0]           floored;

   // load * high * 3 < (low + 1) * 250 is the same test as
   // floor(load * high * 120 / 10000) <= low.
   assign scaled = CMP_BITS'(peak_load) * CMP_BITS'(high_x3);

   always_comb begin
      easy_active_in = easy_active_ff;
      easy_cnt_in    = '0;
      quiet_cnt_in   = quiet_cnt_ff;
      request        = 1'b0;
      target         = freq_high;

      // Easy threshold expiry.
      if (easy_active_ff) begin
         easy_cnt_in = (easy_cnt_ff == dfg_pkg::TICK_MAX) ? easy_cnt_ff
                                                          : easy_cnt_ff + 1'b1;
         if (easy_cnt_in >= ctl.easy_ticks) begin
            easy_active_in = 1'b0;
            easy_cnt_in    = '0;
         end
         if (present_freq == freq_high) begin
            easy_cnt_in = '0;
         end
      end

      threshold = easy_active_in ? ctl.easy_threshold : ctl.hard_threshold;

      if (peak_load > threshold) begin
         request        = 1'b1;
         target         = freq_high;
         quiet_cnt_in   = '0;
         easy_active_in = 1'b1;
      end else begin
         quiet_cnt_in = (quiet_cnt_ff == dfg_pkg::TICK_MAX) ? quiet_cnt_ff
                                                            : quiet_cnt_ff + 1'b1;
         if ((present_freq > freq_low) && (quiet_cnt_in >= ctl.down_ticks)) begin
            quiet_cnt_in = '0;
            if (scaled < low_bound) begin
               request = 1'b1;
               target  = freq_low;
            end
         end
      end

      // Floor first, then ceiling, so the ceiling wins when they cross.
      floored = (target < freq_floor) ? freq_floor : target;
      if (request) begin
         wanted_freq = (floored > freq_ceiling) ? freq_ceiling : floored;
      end else begin
         wanted_freq = present_freq;
      end

      if (wanted_freq > present_freq) begin
         direction = dfg_pkg::DIR_UP;
      end else if (wanted_freq < present_freq) begin
         direction = dfg_pkg::DIR_DOWN;
      end else begin
         direction = dfg_pkg::DIR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         easy_active_ff <= 1'b0;
         easy_cnt_ff    <= '0;
         quiet_cnt_ff   <= '0;
      end else if (step) begin
         easy_active_ff <= easy_active_in;
         easy_cnt_ff    <= easy_cnt_in;
         quiet_cnt_ff   <= quiet_cnt_in;
      end
   end

endmodule

>>> sv/dvfs_frequency_governor.sv
// Two-level on-demand frequency governor, one decision per sample word.
// An accepted req word passes through the input register and then the result register before its rsp word appears.
// Throughput: one word per cycle while rsp_tready holds, set by the combinational decision between the two registers.
// Reset (synchronous, active high) restores the register defaults and clears both counters,
// easy mode and the valid flags of the input and result registers.
// Depends on dfg_pkg, dfg_csr and dfg_core.
`timescale 1ns / 1ps

module dvfs_frequency_governor #(
   parameter int unsigned FREQ_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // Sample words in.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // peak_load [6:0], present_freq [FREQ_BITS+6:7], zero padding above.
   input  logic [((FREQ_BITS+dfg_pkg::LOAD_BITS+7)/8)*8-1:0] req_tdata,
   // Decision words out.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // wanted_freq [FREQ_BITS-1:0], direction [FREQ_BITS+1:FREQ_BITS], zero padding above.
   output logic [((FREQ_BITS+dfg_pkg::DIR_BITS+7)/8)*8-1:0] rsp_tdata,
   // Configuration writes.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_addr,
   input  logic [FREQ_BITS-1:0] csr_data
);

   localparam int unsigned RSP_BITS = ((FREQ_BITS + dfg_pkg::DIR_BITS + 7) / 8) * 8;

   dfg_pkg::ctl_cfg_type                   ctl;
   logic [FREQ_BITS-1:0]                   freq_floor;
   logic [FREQ_BITS-1:0]                   freq_ceiling;
   logic [FREQ_BITS-1:0]                   freq_high;
   logic [FREQ_BITS-1:0]                   freq_low;
   logic [FREQ_BITS+dfg_pkg::NUM_BITS-1:0] high_x3;
   logic [FREQ_BITS+dfg_pkg::DEN_BITS:0]   low_bound;

   // Input register.
   logic                            in_valid_ff, in_valid_in;
   logic [dfg_pkg::LOAD_BITS-1:0]   load_ff, load_in;
   logic [FREQ_BITS-1:0]            present_ff, present_in;

   // Result register.
   logic                            out_valid_ff, out_valid_in;
   logic [FREQ_BITS-1:0]            wanted_ff, wanted_in;
   dfg_pkg::dir_type                dir_ff, dir_in;

   logic                            step;
   logic                            req_take;
   logic [FREQ_BITS-1:0]            core_wanted;
   dfg_pkg::dir_type                core_dir;

   // Configuration is taken in every cycle; the user must write it only while idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   dfg_csr #(
      .FREQ_BITS (FREQ_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .wr_en        (csr_valid),
      .wr_addr      (csr_addr),
      .wr_data      (csr_data),
      .ctl          (ctl),
      .freq_floor   (freq_floor),
      .freq_ceiling (freq_ceiling),
      .freq_high    (freq_high),
      .freq_low     (freq_low),
      .high_x3      (high_x3),
      .low_bound    (low_bound)
   );

   // The word in the input register moves on to the result register, and the
   // governor state advances, whenever the result register is free or is
   // being emptied in this cycle.
   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_take   = req_tvalid && req_tready;

   dfg_core #(
      .FREQ_BITS (FREQ_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .peak_load    (load_ff),
      .present_freq (present_ff),
      .ctl          (ctl),
      .freq_floor   (freq_floor),
      .freq_ceiling (freq_ceiling),
      .freq_high    (freq_high),
      .freq_low     (freq_low),
      .high_x3      (high_x3),
      .low_bound    (low_bound),
      .wanted_freq  (core_wanted),
      .direction    (core_dir)
   );

   always_comb begin
      in_valid_in = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
      load_in     = req_take ? req_tdata[dfg_pkg::LOAD_BITS-1:0] : load_ff;
      present_in  = req_take ? req_tdata[FREQ_BITS+dfg_pkg::LOAD_BITS-1:dfg_pkg::LOAD_BITS]
                             : present_ff;

      out_valid_in = step ? 1'b1 : ((out_valid_ff && rsp_tready) ? 1'b0 : out_valid_ff);
      wanted_in    = step ? core_wanted : wanted_ff;
      dir_in       = step ? core_dir : dir_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      load_ff    <= load_in;
      present_ff <= present_in;
      wanted_ff  <= wanted_in;
      dir_ff     <= dir_in;
   end

   assign rsp_tvalid = out_valid_ff;
   // The zero padding above the direction comes from the widening cast.
   assign rsp_tdata  = RSP_BITS'({dir_ff, wanted_ff});

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the two-level frequency governor: directed corner cases, then
// random load traces under several register settings, all checked against a local predictor.
// Depends on dfg_pkg and the dvfs_frequency_governor RTL; it reads no files.

module testbench;

   localparam int unsigned FREQ_W = 16;
   localparam int unsigned LOAD_W = dfg_pkg::LOAD_BITS;
   localparam int unsigned TICK_W = dfg_pkg::TICK_BITS;
   localparam int unsigned DIR_W  = dfg_pkg::DIR_BITS;
   localparam int unsigned REQ_W  = ((FREQ_W + LOAD_W + 7) / 8) * 8;
   localparam int unsigned RSP_W  = ((FREQ_W + DIR_W + 7) / 8) * 8;

   // Each random phase sends this many sample words; eight phases give about 1500.
   localparam int unsigned PHASE_ITEMS   = 190;
   localparam int unsigned RANDOM_PHASES = 8;

   // The cycle limit sits well above the slowest plausible run.
   localparam longint unsigned CYCLE_LIMIT = 250000;

   // Load is scaled by 1.2 relative to the high level before it is compared with the low one.
   localparam longint unsigned LOAD_SCALE_NUM = 120;
   localparam longint unsigned LOAD_SCALE_DEN = 10000;

   typedef struct packed {
      logic [LOAD_W-1:0] load;
      logic [FREQ_W-1:0] present;
   } sample_type;

   typedef struct packed {
      logic [FREQ_W-1:0] wanted;
      dfg_pkg::dir_type  dir;
   } decision_type;

   // How the register values of one phase are chosen.
   typedef enum {CFG_DEFAULTS, CFG_TYPICAL, CFG_EXTREME, CFG_WILD} cfg_style_type;

   // Shape of a run of samples in the random traffic.
   typedef enum {SEG_QUIET, SEG_BUSY, SEG_NOISE, SEG_BORDER} segment_type;

   // Behaviour of the result side's tready.
   typedef enum {RX_ALWAYS, RX_MOSTLY, RX_SELDOM, RX_PERIODIC} rx_pattern_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   // peak_load [6:0], present_freq [22:7], zero padding above.
   logic [REQ_W-1:0]     req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // wanted_freq [15:0], direction [17:16], zero padding above.
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [2:0]           csr_addr   = dfg_pkg::REG_HARD_THRESHOLD;
   logic [FREQ_W-1:0]    csr_data   = '0;

   // Local copy of the governor's registers and state.
   dfg_pkg::ctl_cfg_type gov_ctl;
   logic [FREQ_W-1:0]    gov_floor, gov_ceiling, gov_high, gov_low;
   logic                 easy_on;
   logic [TICK_W-1:0]    easy_tick_tally, quiet_count;

   sample_type           samples_pending[$];
   decision_type         decisions_due[$];
   int unsigned          queued_total   = 0;
   int unsigned          accepted_total = 0;
   int unsigned          error_count    = 0;
   longint unsigned      cycle_count    = 0;

   dvfs_frequency_governor #(
      .FREQ_BITS(FREQ_W)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic logic [TICK_W-1:0] bump(input logic [TICK_W-1:0] c);
      return (c == dfg_pkg::TICK_MAX) ? c : c + 1'b1;
   endfunction

   // Works out the decision for one sample and advances the local state.
   function automatic decision_type govern_tick(input sample_type s);
      decision_type         d;
      logic [LOAD_W-1:0]    bar;
      logic [FREQ_W-1:0]    target;
      logic                 asked;
      longint unsigned      scaled;
      target = '0;
      asked  = 1'b0;

      // The easy threshold runs out after easy_ticks ticks, but the count is held at zero
      // for as long as the clock already runs at the high level.
      if (easy_on) begin
         easy_tick_tally = bump(easy_tick_tally);
         if (easy_tick_tally >= gov_ctl.easy_ticks) begin
            easy_on         = 1'b0;
            easy_tick_tally = '0;
         end
         if (s.present == gov_high) begin
            easy_tick_tally = '0;
         end
      end else begin
         easy_tick_tally = '0;
      end

      bar = easy_on ? gov_ctl.easy_threshold : gov_ctl.hard_threshold;
      if (s.load > bar) begin
         target      = gov_high;
         asked       = 1'b1;
         quiet_count = '0;
         easy_on     = 1'b1;
      end else begin
         quiet_count = bump(quiet_count);
         if (s.present > gov_low && quiet_count >= gov_ctl.down_ticks) begin
            quiet_count = '0;
            // Full-width product, so a load above 100 cannot overflow it.
            scaled = 64'(s.load) * 64'(gov_high) * LOAD_SCALE_NUM / LOAD_SCALE_DEN;
            if (scaled <= 64'(gov_low)) begin
               target = gov_low;
               asked  = 1'b1;
            end
         end
      end

      // The floor is applied before the ceiling, so the ceiling wins when they cross.
      if (asked) begin
         if (target < gov_floor) begin
            target = gov_floor;
         end
         if (target > gov_ceiling) begin
            target = gov_ceiling;
         end
      end else begin
         target = s.present;
      end

      d.wanted = target;
      if (target > s.present) begin
         d.dir = dfg_pkg::DIR_UP;
      end else if (target < s.present) begin
         d.dir = dfg_pkg::DIR_DOWN;
      end else begin
         d.dir = dfg_pkg::DIR_NONE;
      end
      return d;
   endfunction

   function automatic void note_write(input logic [2:0] idx, input logic [FREQ_W-1:0] val);
      case (idx)
         dfg_pkg::REG_HARD_THRESHOLD: gov_ctl.hard_threshold = val[LOAD_W-1:0];
         dfg_pkg::REG_EASY_THRESHOLD: gov_ctl.easy_threshold = val[LOAD_W-1:0];
         dfg_pkg::REG_EASY_TICKS:     gov_ctl.easy_ticks     = val[TICK_W-1:0];
         dfg_pkg::REG_DOWN_TICKS:     gov_ctl.down_ticks     = val[TICK_W-1:0];
         dfg_pkg::REG_FREQ_FLOOR:     gov_floor              = val;
         dfg_pkg::REG_FREQ_CEILING:   gov_ceiling            = val;
         dfg_pkg::REG_FREQ_HIGH:      gov_high               = val;
         default:                     gov_low                = val;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Sample driver: bursts of random length separated by random gaps.
   // A word is predicted at the edge where it is taken, so the local
   // state advances in exactly the order the block sees the words.
   // ------------------------------------------------------------------

   sample_type  on_wire;
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decisions_due.push_back(govern_tick(on_wire));
            accepted_total++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (samples_pending.size() != 0) begin
               on_wire = samples_pending.pop_front();
               req_tdata  <= REQ_W'({on_wire.present, on_wire.load});
               req_tvalid <= 1'b1;
               if (burst_left <= 1) begin
                  // A third of the bursts run straight into the next one.
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Decision monitor and result-side back-pressure.
   // ------------------------------------------------------------------

   rx_pattern_type rx_mode   = RX_ALWAYS;
   int unsigned    rx_left   = 0;

   always @(posedge clock) begin
      decision_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.wanted = rsp_tdata[FREQ_W-1:0];
            got.dir    = dfg_pkg::dir_type'(rsp_tdata[FREQ_W +: DIR_W]);
            if (decisions_due.size() == 0) begin
               $error("unexpected decision word: wanted_freq %0d, direction %0d",
                      got.wanted, got.dir);
               error_count++;
            end else begin
               want = decisions_due.pop_front();
               if (got.wanted !== want.wanted) begin
                  $error("wanted_freq mismatch: expected %0d, actual %0d",
                         want.wanted, got.wanted);
                  error_count++;
               end
               if (got.dir !== want.dir) begin
                  $error("direction mismatch: expected %0d, actual %0d", want.dir, got.dir);
                  error_count++;
               end
            end
         end

         // The stall pattern changes whenever its countdown rx_left runs out.
         if (rx_left == 0) begin
            rx_mode = rx_pattern_type'($urandom_range(0, 3));
            rx_left = $urandom_range(32, 256);
         end else begin
            rx_left--;
         end
         case (rx_mode)
            RX_ALWAYS:   rsp_tready <= 1'b1;
            RX_MOSTLY:   rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_SELDOM:   rsp_tready <= ($urandom_range(0, 3) == 0);
            default:     rsp_tready <= ((rx_left % 8) < 5);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic void queue_sample(input int unsigned load, input int unsigned present);
      samples_pending.push_back('{load: LOAD_W'(load), present: FREQ_W'(present)});
      queued_total++;
   endfunction

   // Waits until every queued word has been taken and every decision has come back.
   task automatic wait_idle();
      do @(posedge clock);
      while (accepted_total != queued_total || decisions_due.size() != 0);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [FREQ_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_data  <= val;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      note_write(idx, val);
   endtask

   // Threshold and tick values carry random upper bits, which the block must drop.
   function automatic logic [FREQ_W-1:0] threshold_value(input cfg_style_type style);
      int unsigned thr;
      case (style)
         CFG_TYPICAL: thr = $urandom_range(40, 100);
         CFG_EXTREME: begin
            case ($urandom_range(0, 2))
               0:       thr = 0;
               1:       thr = 100;
               default: thr = 127;
            endcase
         end
         default:     thr = $urandom_range(0, 127);
      endcase
      return {9'($urandom), 7'(thr)};
   endfunction

   function automatic logic [FREQ_W-1:0] tick_value(input cfg_style_type style);
      int unsigned ticks;
      case (style)
         CFG_TYPICAL: ticks = $urandom_range(0, 40);
         CFG_EXTREME: begin
            case ($urandom_range(0, 2))
               0:       ticks = 0;
               1:       ticks = 1;
               default: ticks = 255;
            endcase
         end
         default:     ticks = $urandom_range(0, 255);
      endcase
      return {8'($urandom), 8'(ticks)};
   endfunction

   function automatic logic [FREQ_W-1:0] extreme_freq();
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return '1;
         default: return FREQ_W'($urandom);
      endcase
   endfunction

   task automatic program_phase(input cfg_style_type style);
      int unsigned lo, hi, fl, cl;
      if (style == CFG_DEFAULTS) begin
         write_reg(dfg_pkg::REG_HARD_THRESHOLD, FREQ_W'(dfg_pkg::HARD_THRESHOLD_RST));
         write_reg(dfg_pkg::REG_EASY_THRESHOLD, FREQ_W'(dfg_pkg::EASY_THRESHOLD_RST));
         write_reg(dfg_pkg::REG_EASY_TICKS,     FREQ_W'(dfg_pkg::EASY_TICKS_RST));
         write_reg(dfg_pkg::REG_DOWN_TICKS,     FREQ_W'(dfg_pkg::DOWN_TICKS_RST));
         write_reg(dfg_pkg::REG_FREQ_FLOOR,     FREQ_W'(dfg_pkg::FREQ_FLOOR_RST));
         write_reg(dfg_pkg::REG_FREQ_CEILING,   FREQ_W'(dfg_pkg::FREQ_CEILING_RST));
         write_reg(dfg_pkg::REG_FREQ_HIGH,      FREQ_W'(dfg_pkg::FREQ_HIGH_RST));
         write_reg(dfg_pkg::REG_FREQ_LOW,       FREQ_W'(dfg_pkg::FREQ_LOW_RST));
      end else begin
         write_reg(dfg_pkg::REG_HARD_THRESHOLD, threshold_value(style));
         write_reg(dfg_pkg::REG_EASY_THRESHOLD, threshold_value(style));
         write_reg(dfg_pkg::REG_EASY_TICKS,     tick_value(style));
         write_reg(dfg_pkg::REG_DOWN_TICKS,     tick_value(style));
         case (style)
            CFG_TYPICAL: begin
               // An ordered ladder: floor <= low < high <= ceiling.
               lo = $urandom_range(200, 2000);
               hi = lo + $urandom_range(1, 2000);
               fl = lo - $urandom_range(0, 100);
               cl = hi + $urandom_range(0, 100);
               write_reg(dfg_pkg::REG_FREQ_FLOOR,   FREQ_W'(fl));
               write_reg(dfg_pkg::REG_FREQ_CEILING, FREQ_W'(cl));
               write_reg(dfg_pkg::REG_FREQ_HIGH,    FREQ_W'(hi));
               write_reg(dfg_pkg::REG_FREQ_LOW,     FREQ_W'(lo));
            end
            CFG_EXTREME: begin
               write_reg(dfg_pkg::REG_FREQ_FLOOR,   extreme_freq());
               write_reg(dfg_pkg::REG_FREQ_CEILING, extreme_freq());
               write_reg(dfg_pkg::REG_FREQ_HIGH,    extreme_freq());
               write_reg(dfg_pkg::REG_FREQ_LOW,     extreme_freq());
            end
            default: begin
               write_reg(dfg_pkg::REG_FREQ_FLOOR,   FREQ_W'($urandom));
               write_reg(dfg_pkg::REG_FREQ_CEILING, FREQ_W'($urandom));
               write_reg(dfg_pkg::REG_FREQ_HIGH,    FREQ_W'($urandom));
               write_reg(dfg_pkg::REG_FREQ_LOW,     FREQ_W'($urandom));
            end
         endcase
      end
   endtask

   // Present frequencies mostly sit on the configured levels, so that the comparisons
   // against the high and low levels are exercised on both sides.
   function automatic int unsigned pick_present();
      case ($urandom_range(0, 9))
         0:       return gov_high;
         1:       return gov_low;
         2:       return gov_floor;
         3:       return gov_ceiling;
         4:       return FREQ_W'(gov_low + 1'b1);
         5:       return FREQ_W'(gov_high - 1'b1);
         6:       return FREQ_W'(gov_high + 1'b1);
         7:       return FREQ_W'(gov_low - 1'b1);
         8:       return $urandom_range(0, 65535);
         default: return ($urandom_range(0, 1) == 0) ? 0 : 65535;
      endcase
   endfunction

   // Random traffic built from runs of quiet, busy, noisy and borderline loads. With
   // long_quiet set, quiet runs last long enough to drive the quiet count into saturation.
   task automatic queue_traffic(input int unsigned count, input bit long_quiet);
      int unsigned made, seg_len, load, steady, lo_bar, hi_bar;
      segment_type kind;
      made   = 0;
      lo_bar = (gov_ctl.hard_threshold < gov_ctl.easy_threshold) ?
               gov_ctl.hard_threshold : gov_ctl.easy_threshold;
      hi_bar = (gov_ctl.hard_threshold > gov_ctl.easy_threshold) ?
               gov_ctl.hard_threshold : gov_ctl.easy_threshold;
      while (made < count) begin
         kind    = segment_type'($urandom_range(0, 3));
         seg_len = (long_quiet && kind == SEG_QUIET) ? $urandom_range(200, 300)
                                                     : $urandom_range(1, 40);
         steady  = pick_present();
         if (long_quiet && kind == SEG_QUIET && $urandom_range(0, 1) == 0) begin
            steady = gov_low;
         end
         while (seg_len != 0 && made < count) begin
            case (kind)
               SEG_QUIET: load = $urandom_range(0, lo_bar);
               SEG_BUSY:  load = (hi_bar >= 127) ? 127 : $urandom_range(hi_bar + 1, 127);
               SEG_NOISE: load = $urandom_range(0, 127);
               default: begin
                  case ($urandom_range(0, 3))
                     0:       load = lo_bar;
                     1:       load = (lo_bar >= 127) ? 127 : lo_bar + 1;
                     2:       load = hi_bar;
                     default: load = (hi_bar >= 127) ? 127 : hi_bar + 1;
                  endcase
               end
            endcase
            queue_sample(load, ($urandom_range(0, 4) != 0) ? steady : pick_present());
            made++;
            seg_len--;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------

   initial begin
      gov_ctl.hard_threshold = dfg_pkg::HARD_THRESHOLD_RST;
      gov_ctl.easy_threshold = dfg_pkg::EASY_THRESHOLD_RST;
      gov_ctl.easy_ticks     = dfg_pkg::EASY_TICKS_RST;
      gov_ctl.down_ticks     = dfg_pkg::DOWN_TICKS_RST;
      gov_floor              = FREQ_W'(dfg_pkg::FREQ_FLOOR_RST);
      gov_ceiling            = FREQ_W'(dfg_pkg::FREQ_CEILING_RST);
      gov_high               = FREQ_W'(dfg_pkg::FREQ_HIGH_RST);
      gov_low                = FREQ_W'(dfg_pkg::FREQ_LOW_RST);
      easy_on                = 1'b0;
      easy_tick_tally        = '0;
      quiet_count            = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Register defaults straight out of reset: idle, loads at 100 and above 100,
      // easy mode at the high level, and a speed-up from zero.
      queue_sample(0, 0);
      queue_sample(100, 65535);
      queue_sample(76, 1200);
      queue_sample(75, 1000);
      queue_sample(127, 0);
      wait_idle();

      // Zero tick registers and a floor above the ceiling.
      write_reg(dfg_pkg::REG_HARD_THRESHOLD, 16'd50);
      write_reg(dfg_pkg::REG_EASY_THRESHOLD, 16'd20);
      write_reg(dfg_pkg::REG_EASY_TICKS,     16'd0);
      write_reg(dfg_pkg::REG_DOWN_TICKS,     16'd0);
      write_reg(dfg_pkg::REG_FREQ_FLOOR,     16'd1000);
      write_reg(dfg_pkg::REG_FREQ_CEILING,   16'd900);
      write_reg(dfg_pkg::REG_FREQ_HIGH,      16'd0);
      write_reg(dfg_pkg::REG_FREQ_LOW,       16'd100);
      queue_sample(60, 500);
      queue_sample(21, 500);
      queue_sample(0, 101);
      queue_sample(10, 100);
      queue_sample(127, 900);
      queue_sample(0, 65535);
      wait_idle();

      // A request for a high level of zero, with the full frequency range open.
      write_reg(dfg_pkg::REG_HARD_THRESHOLD, 16'd0);
      write_reg(dfg_pkg::REG_EASY_THRESHOLD, 16'd127);
      write_reg(dfg_pkg::REG_FREQ_FLOOR,     16'd0);
      write_reg(dfg_pkg::REG_FREQ_CEILING,   16'hFFFF);
      write_reg(dfg_pkg::REG_FREQ_LOW,       16'd0);
      queue_sample(1, 5);
      queue_sample(0, 3);
      queue_sample(0, 0);
      queue_sample(127, 65535);
      wait_idle();

      // Random phases; phase 3 holds both tick limits at their maximum and uses
      // long quiet runs so that the counters reach saturation.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         program_phase((p == 0) ? CFG_DEFAULTS : cfg_style_type'(1 + p % 3));
         if (p == 3) begin
            write_reg(dfg_pkg::REG_EASY_TICKS, 16'd255);
            write_reg(dfg_pkg::REG_DOWN_TICKS, 16'd255);
         end
         queue_traffic(PHASE_ITEMS, p == 3);
         wait_idle();
      end

      // Leave time for any stray word to show up.
      repeat (8) @(posedge clock);
      if (decisions_due.size() != 0) begin
         $error("%0d decisions never arrived", decisions_due.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> dvfs_frequency_governor.f
sv/dfg_pkg.sv
sv/dfg_csr.sv
sv/dfg_core.sv
sv/dvfs_frequency_governor.sv
bench/testbench.sv
